FILE: rtl/rgpl_pkg.sv
// rgpl_pkg: shared constants for the replay gain loudness block
// no dependencies; imported by the interfaces, the divider and the top level
`default_nettype none
package rgpl_pkg;
	localparam int MAX_FRAMES = 8192;
	localparam int FRAME_AW   = $clog2(MAX_FRAMES);
	localparam int FCNT_W     = FRAME_AW + 1;
	localparam int ESUM_W     = 47;
	localparam int E_W        = 31;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 15;
	localparam int WIN_W      = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_LEVEL = 8'd1;

	localparam logic [WIN_W-1:0]         WS_RESET  = 16'd2205;
	localparam logic signed [GAIN_W-1:0] REF_RESET = -15'sd8062;
	// 10*log10(2) in Q16
	localparam logic [17:0]              DB_COEF   = 18'd197283;
endpackage
`default_nettype wire

FILE: rtl/rgpl_if.sv
// rgpl_if: valid/ready channel interfaces for samples, results and config writes
// depends on rgpl_pkg
`default_nettype none
interface rgpl_in_if;
	import rgpl_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;
	modport source (output valid, sample, last, input ready);
	modport sink   (input valid, sample, last, output ready);
endinterface

interface rgpl_out_if;
	import rgpl_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [GAIN_W-1:0] gain_db;
	logic                     too_short;
	modport source (output valid, gain_db, too_short, input ready);
	modport sink   (input valid, gain_db, too_short, output ready);
endinterface

interface rgpl_cfg_if;
	import rgpl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rgpl_ram.sv
// rgpl_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module rgpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/rgpl_div.sv
// rgpl_div: restoring divider, one quotient bit per cycle
// depends on rgpl_pkg
`default_nettype none
module rgpl_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rgpl_pkg::ESUM_W-1:0] dividend,
	input  wire logic [15:0]                 divisor,
	output logic                             done,
	output logic [rgpl_pkg::ESUM_W-1:0]      quotient
);
	import rgpl_pkg::*;

	localparam int CNT_W = $clog2(ESUM_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       div_q;
	logic [15:0]       rem_q;
	logic [ESUM_W-1:0] quo_q;
	logic [16:0]       rem_sh;
	logic              fits;

	assign rem_sh   = {rem_q, quo_q[ESUM_W-1]};
	assign fits     = rem_sh >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ESUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
			quo_q <= {quo_q[ESUM_W-2:0], fits};
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(start)) else $error("divider done held");
`endif
endmodule
`default_nettype wire

FILE: rtl/replay_gain_percentile_loudness.sv
// replay_gain_percentile_loudness: one sample per cycle while idle; a completed window
// holds off the next sample while the shared 47-step divider forms its mean.
// final sample: rank division, 31 counting passes over the energy ram, normalize
// steps and squaring steps.
// a result sits in an output register while new samples are taken.
// arst_n clears all control state and loads the register reset values; no ram clearing.
`default_nettype none
module replay_gain_percentile_loudness (
	input  wire logic clk,
	input  wire logic arst_n,
	rgpl_in_if.sink   din,
	rgpl_out_if.source dout,
	rgpl_cfg_if.sink  cfg
);
	import rgpl_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WDIV = 4'd1;
	localparam logic [3:0] ST_LAST = 4'd2;
	localparam logic [3:0] ST_RDIV = 4'd3;
	localparam logic [3:0] ST_SEL  = 4'd4;
	localparam logic [3:0] ST_NORM = 4'd5;
	localparam logic [3:0] ST_SQ1  = 4'd6;
	localparam logic [3:0] ST_SQ2  = 4'd7;
	localparam logic [3:0] ST_MUL1 = 4'd8;
	localparam logic [3:0] ST_MUL2 = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0]               state_q;
	logic [WIN_W-1:0]         window_q;
	logic signed [GAIN_W-1:0] ref_q;
	logic                     s1_v_q, last_s1;
	logic [E_W-1:0]           sq_s1;
	logic [ESUM_W-1:0]        sum_q;
	logic [WIN_W-1:0]         cnt_q;
	logic [FCNT_W-1:0]        frames_q;
	logic                     pend_last_q;
	logic [FCNT_W-1:0]        k_q, selcnt_q, addr_q;
	logic [4:0]               bit_q;
	logic [E_W-1:0]           prefix_q;
	logic                     rd_v_s1;
	logic [E_W-1:0]           m_q;
	logic [4:0]               exp_q;
	logic [15:0]              frac_q;
	logic [3:0]               it_q;
	logic [61:0]              prod_q;
	logic [38:0]              prod2_q;
	logic signed [GAIN_W-1:0] res_gain_q;
	logic                     res_ts_q;
	logic                     out_v_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic                     ts_q;

	logic [WIN_W-1:0]  cnt_new, ws_eff;
	logic [ESUM_W-1:0] sum_new;
	logic              complete, event_s1;
	logic              div_start, div_done;
	logic [ESUM_W-1:0] div_dividend, div_quo;
	logic [15:0]       div_divisor;
	logic              ram_we;
	logic [E_W-1:0]    mean, rdata, hi_mask, prefix_one;
	logic              issue, pass_end, match, bit_one;
	logic [31:0]       sq_t;
	logic [20:0]       dval;
	logic [39:0]       mag_sum;
	logic signed [17:0] gsum;
	logic              out_load;
	logic [FCNT_W+4:0] rank_num;

	assign cnt_new  = cnt_q + WIN_W'(1);
	assign ws_eff   = (window_q == '0) ? WIN_W'(1) : window_q;
	assign sum_new  = sum_q + ESUM_W'(sq_s1);
	assign complete = s1_v_q && (cnt_new >= ws_eff) && (cnt_new != '0);
	assign event_s1 = s1_v_q && (complete || last_s1);
	assign din.ready = (state_q == ST_IDLE) && !event_s1;
	assign cfg.ready = 1'b1;

	// 19 * frames by shifts
	assign rank_num = {1'b0, frames_q, 4'b0} + {4'b0, frames_q, 1'b0} + {5'b0, frames_q};

	always_comb begin
		div_start    = 1'b0;
		div_dividend = sum_new;
		div_divisor  = cnt_new;
		if (state_q == ST_IDLE && complete) begin
			div_start = 1'b1;
		end else if (state_q == ST_LAST && frames_q != '0) begin
			div_start    = 1'b1;
			div_dividend = ESUM_W'(rank_num);
			div_divisor  = 16'd20;
		end
	end

	rgpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign mean   = (div_quo[ESUM_W-1:E_W] != '0) ? {E_W{1'b1}} : div_quo[E_W-1:0];
	assign ram_we = (state_q == ST_WDIV) && div_done && (frames_q < FCNT_W'(MAX_FRAMES));

	rgpl_ram #(.WIDTH(E_W), .DEPTH(MAX_FRAMES)) u_energy (
		.clk   (clk),
		.we    (ram_we),
		.waddr (frames_q[FRAME_AW-1:0]),
		.wdata (mean),
		.raddr (addr_q[FRAME_AW-1:0]),
		.rdata (rdata)
	);

	// bitwise rank search: count entries under the resolved prefix with this bit clear
	assign issue      = (state_q == ST_SEL) && (addr_q < frames_q);
	assign pass_end   = (state_q == ST_SEL) && !issue && !rd_v_s1;
	assign hi_mask    = {E_W{1'b1}} << ({1'b0, bit_q} + 6'd1);
	assign match      = (((rdata ^ prefix_q) & hi_mask) == '0) && !rdata[bit_q];
	assign bit_one    = k_q >= selcnt_q;
	assign prefix_one = prefix_q | (E_W'(1) << bit_q);

	assign sq_t    = prod_q[61:30];
	// log2 at or above 30 gives no attenuation
	assign dval    = (exp_q == 5'd30) ? '0
		: ({5'(5'd30 - exp_q), 16'b0} - {5'b0, frac_q});
	assign mag_sum = {1'b0, prod2_q} + 40'd8388608;
	assign gsum    = 18'(ref_q) + $signed({2'b0, mag_sum[39:24]});
	assign out_load = (state_q == ST_FIN) && (!out_v_q || dout.ready);

	assign dout.valid     = out_v_q;
	assign dout.gain_db   = gain_q;
	assign dout.too_short = ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WS_RESET;
			ref_q    <= REF_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_WINDOW_SIZE) begin
				window_q <= cfg.data;
			end else if (cfg.index == CFG_REFERENCE_LEVEL) begin
				ref_q <= cfg.data[GAIN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else begin
			s1_v_q <= din.valid && din.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			sq_s1   <= E_W'(32'(din.sample) * 32'(din.sample));
			last_s1 <= din.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			frames_q    <= '0;
			pend_last_q <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s1_v_q) begin
						if (complete) begin
							sum_q       <= '0;
							cnt_q       <= '0;
							pend_last_q <= last_s1;
							state_q     <= ST_WDIV;
						end else if (last_s1) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_LAST;
						end else begin
							sum_q <= sum_new;
							cnt_q <= cnt_new;
						end
					end
				end
				ST_WDIV: begin
					if (div_done) begin
						if (ram_we) begin
							frames_q <= frames_q + FCNT_W'(1);
						end
						state_q <= pend_last_q ? ST_LAST : ST_IDLE;
					end
				end
				ST_LAST: state_q <= (frames_q == '0) ? ST_FIN : ST_RDIV;
				ST_RDIV: if (div_done) state_q <= ST_SEL;
				ST_SEL: if (pass_end && bit_q == '0) state_q <= ST_NORM;
				ST_NORM: if (m_q[E_W-1]) state_q <= ST_SQ1;
				ST_SQ1: state_q <= ST_SQ2;
				ST_SQ2: state_q <= (it_q == 4'd15) ? ST_MUL1 : ST_SQ1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						frames_q <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			gain_q <= res_gain_q;
			ts_q   <= res_ts_q;
		end
		unique case (state_q)
			ST_LAST: begin
				res_gain_q <= '0;
				res_ts_q   <= 1'b1;
			end
			ST_RDIV: begin
				k_q      <= div_quo[FCNT_W-1:0];
				prefix_q <= '0;
				bit_q    <= 5'(E_W - 1);
				addr_q   <= '0;
				selcnt_q <= '0;
			end
			ST_SEL: begin
				if (issue) begin
					addr_q <= addr_q + FCNT_W'(1);
				end
				if (rd_v_s1 && match) begin
					selcnt_q <= selcnt_q + FCNT_W'(1);
				end
				if (pass_end) begin
					addr_q   <= '0;
					selcnt_q <= '0;
					bit_q    <= bit_q - 5'd1;
					if (bit_one) begin
						k_q      <= k_q - selcnt_q;
						prefix_q <= prefix_one;
					end
					// zero energy counts as one lsb
					m_q   <= ((bit_one ? prefix_one : prefix_q) == '0) ? E_W'(1)
						: (bit_one ? prefix_one : prefix_q);
					exp_q <= 5'(E_W - 1);
					it_q  <= '0;
				end
			end
			ST_NORM: begin
				if (!m_q[E_W-1]) begin
					m_q   <= {m_q[E_W-2:0], 1'b0};
					exp_q <= exp_q - 5'd1;
				end
			end
			ST_SQ1: prod_q <= 62'(m_q) * 62'(m_q);
			ST_SQ2: begin
				m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
				frac_q <= {frac_q[14:0], sq_t[31]};
				it_q   <= it_q + 4'd1;
			end
			ST_MUL1: prod2_q <= 39'(dval) * 39'(DB_COEF);
			ST_MUL2: begin
				res_ts_q <= 1'b0;
				if (gsum > 18'sd16383) begin
					res_gain_q <= 15'sd16383;
				end else if (gsum < -18'sd16384) begin
					res_gain_q <= -15'sd16384;
				end else begin
					res_gain_q <= gsum[GAIN_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_s1_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |-> state_q == ST_IDLE) else $error("sample pending outside idle");
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q <= FCNT_W'(MAX_FRAMES)) else $error("frame count overflow");
	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !rd_v_s1 && state_q == ST_WDIV) else $error("ram write during search");
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_v_q && frames_q == '0 && state_q == ST_IDLE)
		else $error("result load did not clear frames");
`endif
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// testbench: drives sample streams and config writes into replay_gain_percentile_loudness
// and checks every gain result against an in-bench loudness predictor
// depends on rgpl_pkg, rgpl_if and the block itself
`timescale 1ns / 1ps
module testbench;
	import rgpl_pkg::*;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} sample_t;

	typedef struct {
		logic signed [GAIN_W-1:0] gain_db;
		logic                     too_short;
	} gain_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rgpl_in_if  din_if();
	rgpl_out_if dout_if();
	rgpl_cfg_if cfg_if();

	replay_gain_percentile_loudness DUT (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if.sink),
		.dout(dout_if.source),
		.cfg(cfg_if.sink)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sample_t sample_q[$];
	gain_t   gain_q[$];
	int      errors = 0;
	longint  cycles = 0;

	// loudness predictor state
	logic [ESUM_W-1:0]       energy_acc;
	logic [WIN_W-1:0]        win_count;
	int unsigned             frame_count;
	logic [E_W-1:0]          energies[MAX_FRAMES];
	logic [WIN_W-1:0]        win_len;
	logic signed [GAIN_W-1:0] ref_level;

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	function automatic int unsigned log2_q16(input logic [E_W-1:0] e_in);
		int unsigned e, t, n, frac;
		logic [63:0] m;
		e = (e_in == 0) ? 1 : e_in;
		t = e;
		n = 0;
		frac = 0;
		while (t > 1) begin
			t >>= 1;
			n++;
		end
		m = 64'(e) << (30 - n);
		for (int k = 0; k < 16; k++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		return (n << 16) | frac;
	endfunction

	function automatic void predict_loudness(input sample_t it);
		logic [63:0]  sq, mean, d, mag;
		int unsigned  ws, rank, l;
		longint       g;
		logic [E_W-1:0] sorted[$];
		gain_t        res;
		ws = (win_len == 0) ? 1 : win_len;
		sq = 64'(longint'(it.sample) * longint'(it.sample));
		energy_acc = ESUM_W'(64'(energy_acc) + sq);
		win_count = win_count + 1'b1;
		if (win_count >= ws && win_count != 0) begin
			mean = 64'(energy_acc) / 64'(win_count);
			if (mean > 64'h7FFF_FFFF) mean = 64'h7FFF_FFFF;
			if (frame_count < MAX_FRAMES) begin
				energies[frame_count] = mean[E_W-1:0];
				frame_count++;
			end
			energy_acc = '0;
			win_count = '0;
		end
		if (!it.last) return;
		if (frame_count == 0) begin
			res.gain_db = '0;
			res.too_short = 1'b1;
		end else begin
			for (int i = 0; i < frame_count; i++) sorted.push_back(energies[i]);
			sorted.sort();
			rank = (frame_count * 19) / 20;
			if (rank >= frame_count) rank = frame_count - 1;
			l = log2_q16(sorted[rank]);
			d = (l <= (30 << 16)) ? 64'((30 << 16) - l) : 64'd0;
			mag = (d * 64'(DB_COEF) + (64'd1 << 23)) >> 24;
			g = longint'(ref_level) + longint'(mag);
			if (g > 16383) g = 16383;
			if (g < -16384) g = -16384;
			res.gain_db = GAIN_W'(g);
			res.too_short = 1'b0;
		end
		gain_q.push_back(res);
		energy_acc = '0;
		win_count = '0;
		frame_count = 0;
	endfunction

	// sender: bursts and gaps, new item at the falling edge after a transfer
	logic in_xfer = 1'b0;
	int   burst_left = 8;
	int   gap_left = 0;

	always @(negedge clk) begin
		if (!din_if.valid || in_xfer) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				din_if.valid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				din_if.sample <= sample_q[0].sample;
				din_if.last <= sample_q[0].last;
				din_if.valid <= 1'b1;
				void'(sample_q.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	int stall_mode = 0;
	int stall_left = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(5, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: dout_if.ready <= 1'b1;
			1: dout_if.ready <= $urandom_range(0, 1);
			default: dout_if.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// monitor: transfers on both channels at the rising edge
	always @(posedge clk) begin
		gain_t want;
		cycles <= cycles + 1;
		in_xfer <= arst_n && din_if.valid && din_if.ready;
		if (arst_n && din_if.valid && din_if.ready) begin
			sample_t it;
			it.sample = din_if.sample;
			it.last = din_if.last;
			predict_loudness(it);
		end
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (gain_q.size() == 0) begin
				report("unexpected result, gain_db", dout_if.gain_db, 0);
			end else begin
				want = gain_q.pop_front();
				if (dout_if.gain_db !== want.gain_db)
					report("gain_db", dout_if.gain_db, want.gain_db);
				if (dout_if.too_short !== want.too_short)
					report("too_short", dout_if.too_short, want.too_short);
			end
		end
		if (cycles > 3_000_000) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == CFG_WINDOW_SIZE) win_len = val;
		else if (idx == CFG_REFERENCE_LEVEL) ref_level = val[GAIN_W-1:0];
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// wait until the block has taken everything and all results are back
	task automatic drain();
		do @(posedge clk);
		while (sample_q.size() != 0 || din_if.valid || gain_q.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int amp);
		case (amp)
			0: return '0;
			1: return SAMPLE_W'($urandom_range(0, 63)) - 16'sd32;
			2: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_signal(input int n, input bit with_last, input int amp);
		sample_t it;
		for (int i = 0; i < n; i++) begin
			it.sample = pick_sample((amp < 0) ? $urandom_range(0, 3) : amp);
			it.last = with_last && (i == n - 1);
			sample_q.push_back(it);
		end
	endtask

	task automatic push_one(input logic signed [SAMPLE_W-1:0] s, input logic lst);
		sample_t it;
		it.sample = s;
		it.last = lst;
		sample_q.push_back(it);
	endtask

	initial begin
		int sent;
		int len;
		energy_acc = '0;
		win_count = '0;
		frame_count = 0;
		win_len = WS_RESET;
		ref_level = REF_RESET;
		din_if.valid = 1'b0;
		din_if.sample = '0;
		din_if.last = 1'b0;
		dout_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window length, a lone last sample is too short
		push_one(16'sh7FFF, 1'b1);
		drain();

		// full-scale squares with the top reference, gives the highest gain
		write_reg(CFG_WINDOW_SIZE, 16'd4);
		write_reg(CFG_REFERENCE_LEVEL, 16'h3FFF);
		push_one(16'sh7FFF, 1'b0);
		push_one(16'sh8000, 1'b0);
		push_one(16'sh8000, 1'b0);
		push_one(16'sh7FFF, 1'b1);
		drain();

		// silence floors at one lsb, lowest reference
		write_reg(CFG_WINDOW_SIZE, 16'd1);
		write_reg(CFG_REFERENCE_LEVEL, 16'h4000);
		push_signal(3, 1'b1, 0);
		drain();

		// zero window length acts as one
		write_reg(CFG_WINDOW_SIZE, 16'd0);
		push_signal(4, 1'b1, 3);
		drain();

		// longest window, signal never fills it
		write_reg(CFG_WINDOW_SIZE, 16'hFFFF);
		push_signal(5, 1'b1, 3);
		drain();

		// window shrinks while partly filled, plus a write to an unknown index
		write_reg(CFG_WINDOW_SIZE, 16'd8);
		push_signal(5, 1'b0, 3);
		drain();
		write_reg(CFG_WINDOW_SIZE, 16'd2);
		write_reg(8'd7, 16'hFFFF);
		push_signal(3, 1'b1, 3);
		drain();

		sent = 0;
		while (sent < 1500) begin
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(0, 16)));
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_REFERENCE_LEVEL, CFG_DATA_W'($urandom));
			repeat ($urandom_range(1, 4)) begin
				len = $urandom_range(1, 40);
				push_signal(len, $urandom_range(0, 7) != 0, ($urandom_range(0, 1) == 1) ? 3
					: $urandom_range(0, 2));
				sent += len;
			end
			drain();
		end

		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: replay_gain_percentile_loudness.f
rtl/rgpl_pkg.sv
rtl/rgpl_if.sv
rtl/rgpl_ram.sv
rtl/rgpl_div.sv
rtl/replay_gain_percentile_loudness.sv
tb/testbench.sv
